### hw/rtl/kct_pkg.sv
// Shared types, codes and default sizes for the keyed class table.
// Used by the channel interfaces and by every module of the block but kct_ram; depends on nothing.
`timescale 1ns / 1ps

package kct_pkg;

  localparam int unsigned MAX_PINGS     = 64;
  localparam int unsigned MAX_BEAMS     = 256;
  localparam int unsigned MAX_MULTIPING = 4;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned PING_W     = 32;
  localparam int unsigned IDX_W      = 32;
  localparam int unsigned CLASS_W    = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned BEAM_CNT_W = 9;
  localparam int unsigned MP_CNT_W   = 3;
  localparam int unsigned CFG_DATA_W = BEAM_CNT_W;

  localparam logic [BEAM_CNT_W-1:0] BEAM_CNT_RST = BEAM_CNT_W'(256);
  localparam logic [MP_CNT_W-1:0]   MP_CNT_RST   = MP_CNT_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } kct_action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } kct_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEAM_COUNT      = 1'b0,
    CFG_MULTIPING_COUNT = 1'b1
  } kct_cfg_reg_e;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic load_addr;
    logic mem_wr;
    logic sweep_wr;
    logic out_ld;
  } kct_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic need_rd;
    logic need_wr;
    logic sweep_last;
    logic out_busy;
  } kct_sts_t;

endpackage

### hw/rtl/kct_if.sv
// Valid/ready channel interfaces of the keyed class table: input word, result word, config write.
// Depends on kct_pkg for field widths.
`timescale 1ns / 1ps

interface kct_in_if;
  logic                                valid;
  logic                                ready;
  logic [kct_pkg::ACTION_W-1:0]        action;
  logic [kct_pkg::PING_W-1:0]          ping_key;
  logic [kct_pkg::IDX_W-1:0]           beam_index;
  logic [kct_pkg::IDX_W-1:0]           multiping_index;
  logic signed [kct_pkg::CLASS_W-1:0]  class_value;

  modport source (output valid, action, ping_key, beam_index, multiping_index, class_value,
                  input ready);
  modport sink (input valid, action, ping_key, beam_index, multiping_index, class_value,
                output ready);
endinterface

interface kct_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kct_pkg::CLASS_W-1:0]  class_result;
  logic [kct_pkg::STATUS_W-1:0]        status;

  modport source (output valid, class_result, status, input ready);
  modport sink (input valid, class_result, status, output ready);
endinterface

interface kct_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kct_pkg::CFG_IDX_W-1:0]     index;
  logic [kct_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/keyed_class_table.sv
// Top level of the keyed class table: joins the controller and the datapath to the channels.
// Depends on kct_pkg, kct_if, kct_ctrl and kct_datapath.
//
// The block maps 32-bit ping numbers to dense slots in order of first insert and keeps
// a 16-bit class for every slot, beam and multi-ping sub-index in a single-port RAM of
// MAX_PINGS*MAX_BEAMS*MAX_MULTIPING words. A lookup that reads the RAM or an insert that
// writes it goes from accept through the parallel key match, the address multiply-add,
// the RAM access and the load of the result register, and then back to idle to take the
// next word. A lookup or insert that makes no RAM access (unknown ping, index out of
// range, full key map) and the no-operation action skip the access step. The result
// register holds the finished word while the next one is accepted; a word that finds it
// still full waits in its last step until it is taken. A clear fills every RAM word with
// -1, one word a cycle. After reset the same fill runs before the first word is accepted;
// configuration writes are taken at any time.
`timescale 1ns / 1ps

module keyed_class_table #(
  parameter int unsigned MAX_PINGS     = kct_pkg::MAX_PINGS,
  parameter int unsigned MAX_BEAMS     = kct_pkg::MAX_BEAMS,
  parameter int unsigned MAX_MULTIPING = kct_pkg::MAX_MULTIPING
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kct_in_if.sink    in_i,
  kct_out_if.source out_o,
  kct_cfg_if.sink   cfg_i
);

  kct_pkg::kct_cmd_t cmd;
  kct_pkg::kct_sts_t sts;

  assign cfg_i.ready = 1'b1;

  kct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kct_datapath #(
    .MAX_PINGS     (MAX_PINGS),
    .MAX_BEAMS     (MAX_BEAMS),
    .MAX_MULTIPING (MAX_MULTIPING)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_action_i  (in_i.action),
    .in_ping_i    (in_i.ping_key),
    .in_beam_i    (in_i.beam_index),
    .in_mp_i      (in_i.multiping_index),
    .in_class_i   (in_i.class_value),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_class_o  (out_o.class_result),
    .out_status_o (out_o.status)
  );

endmodule

### hw/rtl/kct_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kct_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/kct_ctrl.sv
// Controller of the keyed class table: sequences accept, key search, address, access,
// clearing sweep and result hand-off. Depends on kct_pkg.
`timescale 1ns / 1ps

module kct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kct_pkg::kct_sts_t sts_i,
  output kct_pkg::kct_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_EVAL,
    S_ADDR,
    S_ACCESS,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;

  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    cmd_o   = '0;
    unique case (state_q)
      S_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = emit_q ? S_FINISH : S_IDLE;
          emit_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.load_addr = 1'b1;
        if (sts_i.is_clear) begin
          state_d = S_SWEEP;
          emit_d  = 1'b1;
        end else if (sts_i.need_rd || sts_i.need_wr) begin
          state_d = S_ACCESS;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_ACCESS: begin
        cmd_o.mem_wr = sts_i.need_wr;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

### hw/rtl/kct_datapath.sv
// Datapath of the keyed class table: config registers, key map with cache, address
// arithmetic, class store RAM and result register. Depends on kct_pkg and kct_ram.
`timescale 1ns / 1ps

module kct_datapath #(
  parameter int unsigned MAX_PINGS     = kct_pkg::MAX_PINGS,
  parameter int unsigned MAX_BEAMS     = kct_pkg::MAX_BEAMS,
  parameter int unsigned MAX_MULTIPING = kct_pkg::MAX_MULTIPING
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  kct_pkg::kct_cmd_t                    cmd_i,
  output kct_pkg::kct_sts_t                    sts_o,
  input  logic [kct_pkg::ACTION_W-1:0]         in_action_i,
  input  logic [kct_pkg::PING_W-1:0]           in_ping_i,
  input  logic [kct_pkg::IDX_W-1:0]            in_beam_i,
  input  logic [kct_pkg::IDX_W-1:0]            in_mp_i,
  input  logic signed [kct_pkg::CLASS_W-1:0]   in_class_i,
  input  logic                                 cfg_valid_i,
  input  logic [kct_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [kct_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [kct_pkg::CLASS_W-1:0]   out_class_o,
  output logic [kct_pkg::STATUS_W-1:0]         out_status_o
);

  localparam int unsigned SLOT_W = (MAX_PINGS > 1) ? $clog2(MAX_PINGS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PINGS + 1);
  localparam int unsigned BEAM_W = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
  localparam int unsigned MP_W   = (MAX_MULTIPING > 1) ? $clog2(MAX_MULTIPING) : 1;
  localparam int unsigned EB_W   = $clog2(MAX_BEAMS + 1);
  localparam int unsigned EM_W   = $clog2(MAX_MULTIPING + 1);
  localparam int unsigned BM_W   = $clog2(MAX_BEAMS * MAX_MULTIPING + 1);
  localparam int unsigned TERM_W = BEAM_W + EM_W + 1;
  localparam int unsigned PROD_W = SLOT_W + BM_W + TERM_W;
  localparam int unsigned DEPTH  = MAX_PINGS * MAX_BEAMS * MAX_MULTIPING;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam int unsigned CW     = kct_pkg::CLASS_W;

  // Configuration.
  logic [kct_pkg::BEAM_CNT_W-1:0] beam_cnt_q;
  logic [kct_pkg::MP_CNT_W-1:0]   mp_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_cnt_q <= kct_pkg::BEAM_CNT_RST;
      mp_cnt_q   <= kct_pkg::MP_CNT_RST;
    end else if (cfg_valid_i) begin
      unique case (kct_pkg::kct_cfg_reg_e'(cfg_idx_i))
        kct_pkg::CFG_BEAM_COUNT:      beam_cnt_q <= cfg_data_i[kct_pkg::BEAM_CNT_W-1:0];
        kct_pkg::CFG_MULTIPING_COUNT: mp_cnt_q   <= cfg_data_i[kct_pkg::MP_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input word.
  kct_pkg::kct_action_e              action_q;
  logic [kct_pkg::PING_W-1:0]        ping_q;
  logic [kct_pkg::IDX_W-1:0]         beam_q;
  logic [kct_pkg::IDX_W-1:0]         mp_q;
  logic [CW-1:0]                     cls_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      action_q <= kct_pkg::kct_action_e'(in_action_i);
      ping_q   <= in_ping_i;
      beam_q   <= in_beam_i;
      mp_q     <= in_mp_i;
      cls_q    <= in_class_i;
    end
  end

  // Effective counts and range check.
  logic [EB_W-1:0] eff_b;
  logic [EM_W-1:0] eff_m;
  logic            in_range;

  always_comb begin
    if (32'(beam_cnt_q) > 32'(MAX_BEAMS)) begin
      eff_b = EB_W'(MAX_BEAMS);
    end else begin
      eff_b = EB_W'(beam_cnt_q);
    end
    if (32'(mp_cnt_q) > 32'(MAX_MULTIPING)) begin
      eff_m = EM_W'(MAX_MULTIPING);
    end else begin
      eff_m = EM_W'(mp_cnt_q);
    end
    in_range = (beam_q < 32'(eff_b)) && (mp_q < 32'(eff_m));
  end

  // Key map and one-entry cache.
  logic [kct_pkg::PING_W-1:0] keys_q [MAX_PINGS];
  logic [CNT_W-1:0]           slot_count_q;
  logic                       cache_valid_q;
  logic [kct_pkg::PING_W-1:0] cache_ping_q;
  logic                       cache_found_q;
  logic [SLOT_W-1:0]          cache_slot_q;

  logic              srch_found;
  logic [SLOT_W-1:0] srch_slot;

  // The lowest matching slot wins.
  always_comb begin
    srch_found = 1'b0;
    srch_slot  = '0;
    for (int i = MAX_PINGS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < slot_count_q) && (keys_q[i] == ping_q)) begin
        srch_found = 1'b1;
        srch_slot  = SLOT_W'(i);
      end
    end
  end

  logic                 e_rd, e_wr, e_clr, hit_found, have;
  logic [SLOT_W-1:0]    e_slot;
  logic [CW-1:0]        e_class;
  kct_pkg::kct_status_e e_status;
  logic                 key_wr, cnt_inc, cache_upd, cache_drop;

  always_comb begin
    e_rd       = 1'b0;
    e_wr       = 1'b0;
    e_clr      = 1'b0;
    hit_found  = 1'b0;
    have       = 1'b0;
    e_slot     = '0;
    e_class    = '0;
    e_status   = kct_pkg::ST_OK;
    key_wr     = 1'b0;
    cnt_inc    = 1'b0;
    cache_upd  = 1'b0;
    cache_drop = 1'b0;
    unique case (action_q)
      kct_pkg::ACT_LOOKUP: begin
        e_class = '1;
        if (ping_q[kct_pkg::PING_W-1] || !in_range) begin
          e_status = kct_pkg::ST_RANGE;
        end else begin
          if (cache_valid_q && (cache_ping_q == ping_q)) begin
            hit_found = cache_found_q;
            e_slot    = cache_slot_q;
          end else begin
            hit_found = srch_found;
            e_slot    = srch_slot;
            cache_upd = 1'b1;
          end
          if (hit_found) begin
            e_rd = 1'b1;
          end else begin
            e_status = kct_pkg::ST_NOT_FOUND;
          end
        end
      end
      kct_pkg::ACT_INSERT: begin
        cache_drop = 1'b1;
        if (srch_found) begin
          e_slot = srch_slot;
          have   = 1'b1;
        end else if (slot_count_q < CNT_W'(MAX_PINGS)) begin
          e_slot  = slot_count_q[SLOT_W-1:0];
          key_wr  = 1'b1;
          cnt_inc = 1'b1;
          have    = 1'b1;
        end
        if (!have) begin
          e_status = kct_pkg::ST_FULL;
        end else if (!in_range) begin
          e_status = kct_pkg::ST_RANGE;
        end else begin
          e_wr = 1'b1;
        end
      end
      kct_pkg::ACT_CLEAR: begin
        e_clr      = 1'b1;
        cache_drop = 1'b1;
      end
      kct_pkg::ACT_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && key_wr) begin
      keys_q[e_slot] <= ping_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q  <= '0;
      cache_valid_q <= 1'b0;
      cache_ping_q  <= '0;
      cache_found_q <= 1'b0;
      cache_slot_q  <= '0;
    end else if (cmd_i.eval) begin
      if (e_clr) begin
        slot_count_q <= '0;
      end else if (cnt_inc) begin
        slot_count_q <= slot_count_q + CNT_W'(1);
      end
      if (cache_drop) begin
        cache_valid_q <= 1'b0;
        cache_ping_q  <= '0;
        cache_found_q <= 1'b0;
        cache_slot_q  <= '0;
      end else if (cache_upd) begin
        cache_valid_q <= 1'b1;
        cache_ping_q  <= ping_q;
        cache_found_q <= srch_found;
        cache_slot_q  <= srch_slot;
      end
    end
  end

  // Per-item results and address terms.
  logic                 need_rd_q, need_wr_q, is_clear_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [CW-1:0]        res_class_q;
  kct_pkg::kct_status_e res_status_q;
  logic [BM_W-1:0]      bm_q;
  logic [TERM_W-1:0]    term_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [PROD_W-1:0]    addr_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_rd_q  <= 1'b0;
      need_wr_q  <= 1'b0;
      is_clear_q <= 1'b0;
    end else if (cmd_i.eval) begin
      need_rd_q  <= e_rd;
      need_wr_q  <= e_wr;
      is_clear_q <= e_clr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      slot_q       <= e_slot;
      res_class_q  <= e_class;
      res_status_q <= e_status;
      bm_q         <= BM_W'(BM_W'(eff_b) * BM_W'(eff_m));
      term_q       <= TERM_W'(TERM_W'(beam_q[BEAM_W-1:0]) * TERM_W'(eff_m))
                      + TERM_W'(mp_q[MP_W-1:0]);
    end
    if (cmd_i.load_addr) begin
      addr_q <= addr_full[ADDR_W-1:0];
    end
  end

  assign addr_full = PROD_W'(slot_q) * PROD_W'(bm_q) + PROD_W'(term_q);

  // Class store and clearing sweep.
  logic [ADDR_W-1:0] sweep_cnt_q;
  logic [ADDR_W-1:0] ram_addr;
  logic [CW-1:0]     ram_wdata;
  logic [CW-1:0]     ram_rdata;
  logic              sweep_last;

  assign sweep_last = (sweep_cnt_q == LAST_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep_wr) begin
      sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + ADDR_W'(1);
    end
  end

  assign ram_addr  = cmd_i.sweep_wr ? sweep_cnt_q : addr_q;
  assign ram_wdata = cmd_i.sweep_wr ? '1 : cls_q;

  kct_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_wr || cmd_i.sweep_wr),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Result register.
  logic                 out_valid_q;
  logic [CW-1:0]        out_class_q;
  kct_pkg::kct_status_e out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_class_q  <= need_rd_q ? ram_rdata : res_class_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_class_o  = out_class_q;
  assign out_status_o = out_status_q;

  assign sts_o.is_clear   = is_clear_q;
  assign sts_o.need_rd    = need_rd_q;
  assign sts_o.need_wr    = need_wr_q;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

### test/keyed_class_table_test.sv
// Self-checking testbench for keyed_class_table: directed and random lookups, inserts and
// clears over several count settings, checked word by word by a scoreboard class.
// Depends on kct_pkg, the channel interfaces in kct_if and the keyed_class_table RTL.
`timescale 1ns / 1ps

module keyed_class_table_test;

  localparam int unsigned TABLE_DEPTH = kct_pkg::MAX_PINGS * kct_pkg::MAX_BEAMS
                                        * kct_pkg::MAX_MULTIPING;
  localparam int unsigned QUIET_LIMIT = 300000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_WORDS = 100;
  localparam int unsigned CFG_W = kct_pkg::CFG_DATA_W;
  localparam int unsigned MPC_W = kct_pkg::MP_CNT_W;
  localparam int unsigned CLS_W = kct_pkg::CLASS_W;

  typedef struct {
    kct_pkg::kct_action_e               action;
    logic [kct_pkg::PING_W-1:0]         ping;
    logic [kct_pkg::IDX_W-1:0]          beam;
    logic [kct_pkg::IDX_W-1:0]          mp;
    logic signed [kct_pkg::CLASS_W-1:0] cls;
  } class_req_t;

  typedef struct {
    logic signed [kct_pkg::CLASS_W-1:0] cls;
    kct_pkg::kct_status_e               status;
  } class_resp_t;

  class kct_scoreboard;
    logic [kct_pkg::BEAM_CNT_W-1:0]     beam_count;
    logic [kct_pkg::MP_CNT_W-1:0]       mp_count;
    logic [kct_pkg::PING_W-1:0]         slot_keys [kct_pkg::MAX_PINGS];
    int unsigned                        slot_count;
    logic signed [kct_pkg::CLASS_W-1:0] class_mem [TABLE_DEPTH];
    bit                                 cache_valid;
    logic [kct_pkg::PING_W-1:0]         cache_ping;
    bit                                 cache_found;
    int unsigned                        cache_slot;
    class_resp_t                        expected_words [$];
    int unsigned                        errors;

    function new();
      beam_count = kct_pkg::BEAM_CNT_RST;
      mp_count = kct_pkg::MP_CNT_RST;
      errors = 0;
      wipe();
    endfunction

    function void drop_cache();
      cache_valid = 1'b0;
      cache_ping = '0;
      cache_found = 1'b0;
      cache_slot = 0;
    endfunction

    function void wipe();
      foreach (class_mem[i]) class_mem[i] = -16'sd1;
      slot_count = 0;
      drop_cache();
    endfunction

    function int unsigned eff_beams();
      return (beam_count > kct_pkg::MAX_BEAMS) ? kct_pkg::MAX_BEAMS : beam_count;
    endfunction

    function int unsigned eff_mp();
      return (mp_count > kct_pkg::MAX_MULTIPING) ? kct_pkg::MAX_MULTIPING : mp_count;
    endfunction

    function void set_register(kct_pkg::kct_cfg_reg_e idx,
                               logic [kct_pkg::CFG_DATA_W-1:0] data);
      if (idx == kct_pkg::CFG_BEAM_COUNT) begin
        beam_count = data;
      end else begin
        mp_count = data[kct_pkg::MP_CNT_W-1:0];
      end
    endfunction

    function bit find_slot(input logic [kct_pkg::PING_W-1:0] ping, output int unsigned slot);
      slot = 0;
      for (int unsigned i = 0; i < slot_count; i++) begin
        if (slot_keys[i] == ping) begin
          slot = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int unsigned table_addr(int unsigned slot, logic [kct_pkg::IDX_W-1:0] beam,
                                     logic [kct_pkg::IDX_W-1:0] mp);
      int unsigned a;
      a = slot * (eff_beams() * eff_mp()) + beam * eff_mp() + mp;
      return (a < TABLE_DEPTH) ? a : 0;
    endfunction

    function void note_word(class_req_t req);
      class_resp_t exp;
      int unsigned slot;
      bit found;
      bit in_range;
      in_range = (req.beam < eff_beams()) && (req.mp < eff_mp());
      slot = 0;
      exp.cls = '0;
      exp.status = kct_pkg::ST_OK;
      case (req.action)
        kct_pkg::ACT_LOOKUP: begin
          exp.cls = -16'sd1;
          if (req.ping > 32'h7FFF_FFFF || !in_range) begin
            exp.status = kct_pkg::ST_RANGE;
          end else begin
            if (cache_valid && cache_ping == req.ping) begin
              found = cache_found;
              slot = cache_slot;
            end else begin
              found = find_slot(req.ping, slot);
              if (!found) slot = 0;
              cache_valid = 1'b1;
              cache_ping = req.ping;
              cache_found = found;
              cache_slot = slot;
            end
            if (found) begin
              exp.cls = class_mem[table_addr(slot, req.beam, req.mp)];
            end else begin
              exp.status = kct_pkg::ST_NOT_FOUND;
            end
          end
        end
        kct_pkg::ACT_INSERT: begin
          found = find_slot(req.ping, slot);
          drop_cache();
          if (!found && slot_count < kct_pkg::MAX_PINGS) begin
            slot = slot_count;
            slot_keys[slot] = req.ping;
            slot_count++;
            found = 1'b1;
          end
          if (!found) begin
            exp.status = kct_pkg::ST_FULL;
          end else if (!in_range) begin
            exp.status = kct_pkg::ST_RANGE;
          end else begin
            class_mem[table_addr(slot, req.beam, req.mp)] = req.cls;
          end
        end
        kct_pkg::ACT_CLEAR: begin
          wipe();
        end
        default: begin
        end
      endcase
      expected_words.push_back(exp);
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic signed [kct_pkg::CLASS_W-1:0] cls,
                    logic [kct_pkg::STATUS_W-1:0] status);
      class_resp_t exp;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected result word class %0d status %0d", cls, status));
      end else begin
        exp = expected_words.pop_front();
        if (cls !== exp.cls) begin
          report($sformatf("class_result %0d, expected %0d", cls, exp.cls));
        end
        if (status !== exp.status) begin
          report($sformatf("status %0d, expected %0d", status, exp.status));
        end
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kct_in_if  in_if ();
  kct_out_if out_if ();
  kct_cfg_if cfg_if ();

  keyed_class_table DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  kct_scoreboard board = new();

  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  int unsigned clear_budget = 5;
  int unsigned quiet_cycles = 0;
  logic [kct_pkg::PING_W-1:0] last_ping = '0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("keyed_class_table_test: done, errors");
      $finish;
    end
  end

  function automatic class_req_t mk_req(kct_pkg::kct_action_e action,
                                        logic [kct_pkg::PING_W-1:0] ping,
                                        logic [kct_pkg::IDX_W-1:0] beam,
                                        logic [kct_pkg::IDX_W-1:0] mp,
                                        logic signed [kct_pkg::CLASS_W-1:0] cls);
    class_req_t req;
    req.action = action;
    req.ping = ping;
    req.beam = beam;
    req.mp = mp;
    req.cls = cls;
    return req;
  endfunction

  function automatic logic [kct_pkg::IDX_W-1:0] pick_index(int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom;
    if (r == 1) return lim;
    if (lim == 0) return $urandom_range(0, 3);
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic class_req_t random_req(int unsigned new_pct);
    class_req_t req;
    int unsigned r;
    r = $urandom_range(0, 299);
    if (r == 0 && clear_budget > 0) begin
      req.action = kct_pkg::ACT_CLEAR;
      clear_budget--;
    end else if (r < 15) begin
      req.action = kct_pkg::ACT_NOP;
    end else if (r < 150) begin
      req.action = kct_pkg::ACT_LOOKUP;
    end else begin
      req.action = kct_pkg::ACT_INSERT;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      req.ping = $urandom;
    end else if (r < 25) begin
      req.ping = last_ping;
    end else if (board.slot_count == 0 || (r - 25) < new_pct * 75 / 100) begin
      req.ping = $urandom & 32'h7FFF_FFFF;
    end else begin
      req.ping = board.slot_keys[$urandom_range(0, board.slot_count - 1)];
    end
    req.beam = pick_index(board.eff_beams());
    req.mp = pick_index(board.eff_mp());
    req.cls = CLS_W'($urandom);
    return req;
  endfunction

  task automatic send_req(class_req_t req);
    int unsigned gap;
    gap = src_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= req.action;
    in_if.ping_key <= req.ping;
    in_if.beam_index <= req.beam;
    in_if.multiping_index <= req.mp;
    in_if.class_value <= req.cls;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_word(req);
    last_ping = req.ping;
  endtask

  task automatic program_counts(logic [kct_pkg::CFG_DATA_W-1:0] beams,
                                logic [kct_pkg::CFG_DATA_W-1:0] mps);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= kct_pkg::CFG_BEAM_COUNT;
    cfg_if.data <= beams;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.set_register(kct_pkg::CFG_BEAM_COUNT, beams);
    cfg_if.index <= kct_pkg::CFG_MULTIPING_COUNT;
    cfg_if.data <= mps;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.set_register(kct_pkg::CFG_MULTIPING_COUNT, mps);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.expected_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      board.check_word(out_if.class_result, out_if.status);
    end
  end

  initial begin
    int unsigned beam_cfg [PHASES];
    int unsigned mp_cfg [PHASES];
    beam_cfg = '{256, 1, 0, 511, 16, 256, 3, 100};
    mp_cfg = '{4, 1, 3, 0, 2, 1, 4, 5};
    in_if.valid <= 1'b0;
    in_if.action <= kct_pkg::ACT_NOP;
    in_if.ping_key <= '0;
    in_if.beam_index <= '0;
    in_if.multiping_index <= '0;
    in_if.class_value <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= kct_pkg::CFG_BEAM_COUNT;
    cfg_if.data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Oversized counts first: they act as the largest beam and sub-index counts.
    program_counts(9'd300, {6'($urandom), 3'd7});
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'd5, 32'd0, 32'd0, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'd5, 32'd255, 32'd3, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_INSERT, 32'd5, 32'd0, 32'd0, 16'sh7FFF));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'd5, 32'd0, 32'd0, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'd255, 32'd3, 16'sh8000));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'd255, 32'd3, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 32'd0, 32'd0, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_INSERT, 32'd0, 32'd256, 32'd0, 16'sh1234));
    send_req(mk_req(kct_pkg::ACT_INSERT, 32'd0, 32'd0, 32'd4, 16'sh1234));
    send_req(mk_req(kct_pkg::ACT_INSERT, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'shFFFF));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'd0, 32'd255, 32'd3, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'd5, 32'd256, 32'd0, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    16'shFFFF));
    send_req(mk_req(kct_pkg::ACT_INSERT, 32'd0, 32'd255, 32'd3, 16'sd1));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'd0, 32'd255, 32'd3, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'd5, 32'd0, 32'd0, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_CLEAR, 32'd5, 32'd0, 32'd0, 16'sd0));
    send_req(mk_req(kct_pkg::ACT_LOOKUP, 32'd5, 32'd0, 32'd0, 16'sd0));
    in_if.valid <= 1'b0;
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      src_steady = (p % 3 == 1);
      sink_steady = (p % 4 == 2);
      program_counts(CFG_W'(beam_cfg[p]), {6'($urandom), MPC_W'(mp_cfg[p])});
      for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
        send_req(random_req((p % 2 == 0) ? 70 : 10));
      end
      in_if.valid <= 1'b0;
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("keyed_class_table_test: done, clean");
    end else begin
      $display("keyed_class_table_test: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/kct_pkg.sv
hw/rtl/kct_if.sv
hw/rtl/kct_ram.sv
hw/rtl/kct_ctrl.sv
hw/rtl/kct_datapath.sv
hw/rtl/keyed_class_table.sv
test/keyed_class_table_test.sv
